// File: rtl/core/pedc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedc_pkg
// Shared types, codes and constants of the parameter-edit display controller.
// ----------------------------------------------------------------------------
package pedc_pkg;

   // timestamp width, elapsed time is taken modulo 2^TIME_BITS
   localparam int TIME_BITS = 32;

   localparam int CSR_COUNT  = 8;
   localparam int CSR_IDX_W  = $clog2(CSR_COUNT);
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_MIN   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_MAX   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_MIN   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_MAX   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_MIN  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_MAX  = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MS = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_MS   = CSR_IDX_W'(7);

   localparam logic [7:0]  RST_FOLD_MIN   = 8'd60;
   localparam logic [7:0]  RST_FOLD_MAX   = 8'd179;
   localparam logic [7:0]  RST_INIT_MIN   = 8'd0;
   localparam logic [7:0]  RST_INIT_MAX   = 8'd60;
   localparam logic [7:0]  RST_SPEED_MIN  = 8'd0;
   localparam logic [7:0]  RST_SPEED_MAX  = 8'd5;
   localparam logic [15:0] RST_TIMEOUT_MS = 16'd5000;
   localparam logic [15:0] RST_BLINK_MS   = 16'd350;

   localparam logic [1:0] CMD_REFRESH = 2'd0;
   localparam logic [1:0] CMD_CYCLE   = 2'd1;
   localparam logic [1:0] CMD_ADJUST  = 2'd2;
   localparam logic [1:0] CMD_EXIT    = 2'd3;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_FOLD   = 2'd1;
   localparam logic [1:0] MODE_INIT   = 2'd2;
   localparam logic [1:0] MODE_SPEED  = 2'd3;

   localparam logic [1:0] WK_NONE   = 2'd0;
   localparam logic [1:0] WK_LIVE   = 2'd1;
   localparam logic [1:0] WK_COMMIT = 2'd2;

   localparam logic [9:0] SHOW_MAX = 10'd999;

   typedef struct packed {
      logic [1:0]        command;
      logic [31:0]       now_ms;
      logic signed [7:0] step;
      logic              save;
      logic [7:0]        stored_value;
      logic [9:0]        live_angle;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [1:0] write_kind;
      logic [1:0] write_target;
      logic [7:0] write_value;
      logic       display_valid;
      logic [1:0] mode_digit;
      logic       value_shown;
      logic       hundreds_on;
      logic [3:0] hundreds_digit;
      logic       tens_on;
      logic [3:0] tens_digit;
      logic [3:0] ones_digit;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  fold_min;
      logic [7:0]  fold_max;
      logic [7:0]  init_min;
      logic [7:0]  init_max;
      logic [7:0]  speed_min;
      logic [7:0]  speed_max;
      logic [15:0] timeout_ms;
      logic [15:0] blink_ms;
   } cfg_type;

   typedef struct packed {
      logic       hundreds_on;
      logic [3:0] hundreds_digit;
      logic       tens_on;
      logic [3:0] tens_digit;
      logic [3:0] ones_digit;
   } digits_type;

endpackage

// File: rtl/core/pedc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedc_csr
// Configuration registers: clamp limits, edit timeout and blink half period.
// ----------------------------------------------------------------------------
module pedc_csr import pedc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FOLD_MIN:   cfg_in.fold_min   = csr_wdata[7:0];
            CSR_FOLD_MAX:   cfg_in.fold_max   = csr_wdata[7:0];
            CSR_INIT_MIN:   cfg_in.init_min   = csr_wdata[7:0];
            CSR_INIT_MAX:   cfg_in.init_max   = csr_wdata[7:0];
            CSR_SPEED_MIN:  cfg_in.speed_min  = csr_wdata[7:0];
            CSR_SPEED_MAX:  cfg_in.speed_max  = csr_wdata[7:0];
            CSR_TIMEOUT_MS: cfg_in.timeout_ms = csr_wdata[15:0];
            CSR_BLINK_MS:   cfg_in.blink_ms   = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fold_min   <= RST_FOLD_MIN;
         cfg_ff.fold_max   <= RST_FOLD_MAX;
         cfg_ff.init_min   <= RST_INIT_MIN;
         cfg_ff.init_max   <= RST_INIT_MAX;
         cfg_ff.speed_min  <= RST_SPEED_MIN;
         cfg_ff.speed_max  <= RST_SPEED_MAX;
         cfg_ff.timeout_ms <= RST_TIMEOUT_MS;
         cfg_ff.blink_ms   <= RST_BLINK_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/pedc_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedc_digits
// Saturates a value at 999 and splits it into three decimal digits with
// leading-zero flags.
// ----------------------------------------------------------------------------
module pedc_digits import pedc_pkg::*; (
   input  logic [9:0]  value,
   output digits_type  digits
);

   logic [9:0]  sat;
   logic [15:0] h_prod;
   logic [3:0]  hund;
   logic [9:0]  h_rem;
   logic [6:0]  rem;
   logic [13:0] t_prod;
   logic [3:0]  tens;
   logic [6:0]  t_rem;

   always_comb begin
      sat    = (value > SHOW_MAX) ? SHOW_MAX : value;
      // divide by 100: x * 41 / 4096 is exact below 1000
      h_prod = 16'(sat) * 16'd41;
      hund   = h_prod[15:12];
      h_rem  = sat - 10'(hund) * 10'd100;
      rem    = h_rem[6:0];
      // divide by 10: x * 103 / 1024 is exact below 100
      t_prod = 14'(rem) * 14'd103;
      tens   = t_prod[13:10];
      t_rem  = rem - 7'(tens) * 7'd10;

      digits.hundreds_on    = (sat >= 10'd100);
      digits.hundreds_digit = hund;
      digits.tens_on        = (sat >= 10'd10);
      digits.tens_digit     = tens;
      digits.ones_digit     = t_rem[3:0];
   end

endmodule

// File: rtl/core/pedc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedc_core
// Edit state (mode, value, blink, timestamps) and the per-word command logic:
// cycle, adjust with clamping, exit and refresh with timeout and blink.
// ----------------------------------------------------------------------------
module pedc_core import pedc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [1:0]           mode_ff, mode_in;
   logic [7:0]           value_ff, value_in;
   logic                 blink_ff, blink_in;
   logic [TIME_BITS-1:0] act_time_ff, act_time_in;
   logic [TIME_BITS-1:0] blink_time_ff, blink_time_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] act_elapsed;
   logic [TIME_BITS-1:0] blink_elapsed;
   logic                 timed_out;
   logic                 blink_due;
   logic [1:0]           mode_after;
   logic                 blink_after;
   logic                 visible;
   logic [9:0]           show_value;
   digits_type           digits;

   logic [7:0]           lo;
   logic [7:0]           hi;
   logic signed [9:0]    sum;
   logic [7:0]           clamped;

   pedc_digits u_digits (
      .value  (show_value),
      .digits (digits)
   );

   always_comb begin
      now_t         = TIME_BITS'(item.now_ms);
      act_elapsed   = now_t - act_time_ff;
      blink_elapsed = now_t - blink_time_ff;
      timed_out     = (mode_ff != MODE_NORMAL) &&
                      (act_elapsed >= TIME_BITS'(cfg.timeout_ms));
      mode_after    = timed_out ? MODE_NORMAL : mode_ff;
      blink_due     = (mode_after != MODE_NORMAL) &&
                      (blink_elapsed >= TIME_BITS'(cfg.blink_ms));
      blink_after   = blink_due ? ~blink_ff : blink_ff;
      visible       = (mode_after == MODE_NORMAL) || blink_after;
      show_value    = (mode_after == MODE_NORMAL) ? item.live_angle
                                                  : {2'b00, value_ff};

      unique case (mode_ff)
         MODE_FOLD: begin
            lo = cfg.fold_min;
            hi = cfg.fold_max;
         end
         MODE_INIT: begin
            lo = cfg.init_min;
            hi = cfg.init_max;
         end
         MODE_SPEED: begin
            lo = cfg.speed_min;
            hi = cfg.speed_max;
         end
         default: begin
            lo = 8'd0;
            hi = 8'd0;
         end
      endcase

      sum = $signed({2'b00, value_ff}) + $signed({{2{item.step[7]}}, item.step});
      // min is tested first, so crossed limits give min for low values
      priority if (sum < $signed({2'b00, lo})) begin
         clamped = lo;
      end else if (sum > $signed({2'b00, hi})) begin
         clamped = hi;
      end else begin
         clamped = sum[7:0];
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      value_in      = value_ff;
      blink_in      = blink_ff;
      act_time_in   = act_time_ff;
      blink_time_in = blink_time_ff;
      result        = '0;

      unique case (item.command)
         CMD_REFRESH: begin
            if (timed_out) begin
               result.write_kind   = WK_COMMIT;
               result.write_target = mode_ff;
               result.write_value  = value_ff;
            end
            mode_in  = mode_after;
            blink_in = blink_after;
            if (blink_due) begin
               blink_time_in = now_t;
            end
            result.display_valid = 1'b1;
            result.mode_digit    = mode_after;
            if (visible) begin
               result.value_shown    = 1'b1;
               result.hundreds_on    = digits.hundreds_on;
               result.hundreds_digit = digits.hundreds_digit;
               result.tens_on        = digits.tens_on;
               result.tens_digit     = digits.tens_digit;
               result.ones_digit     = digits.ones_digit;
            end
         end
         CMD_CYCLE: begin
            mode_in       = mode_ff + 2'd1;
            blink_in      = 1'b1;
            act_time_in   = now_t;
            blink_time_in = now_t;
            if (mode_in != MODE_NORMAL) begin
               value_in = item.stored_value;
            end
            if (mode_ff != MODE_NORMAL) begin
               result.write_kind   = WK_COMMIT;
               result.write_target = mode_ff;
               result.write_value  = value_ff;
            end
         end
         CMD_ADJUST: begin
            if (mode_ff == MODE_NORMAL) begin
               result.status = 1'b1;
            end else begin
               value_in            = clamped;
               act_time_in         = now_t;
               blink_in            = 1'b1;
               blink_time_in       = now_t;
               result.write_kind   = WK_LIVE;
               result.write_target = mode_ff;
               result.write_value  = clamped;
            end
         end
         CMD_EXIT: begin
            mode_in = MODE_NORMAL;
            if (item.save && (mode_ff != MODE_NORMAL)) begin
               result.write_kind   = WK_COMMIT;
               result.write_target = mode_ff;
               result.write_value  = value_ff;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         value_ff      <= 8'd0;
         blink_ff      <= 1'b1;
         act_time_ff   <= '0;
         blink_time_ff <= '0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         value_ff      <= value_in;
         blink_ff      <= blink_in;
         act_time_ff   <= act_time_in;
         blink_time_ff <= blink_time_in;
      end
   end

endmodule

// File: rtl/core/param_edit_display_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// param_edit_display_controller
// Parameter-edit controller for a four-digit display: mode cycling, clamped
// adjust, exit with optional save, and refresh with timeout, blink and digits.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data  (req_type)
//   rsp      out        rsp_valid/rsp_ready  rsp_data  (rsp_type)
//   csr      in         csr_write_en         csr_index, csr_wdata
//
// One word per cycle sustained while rsp_ready is high; an accepted word goes
// through the input register and then the output register before it is on rsp.
// The command is decoded against the edit state from an input register into
// an output register in a single pass.
// Reset is synchronous: both stages empty, registers at their reset values.
// A stalled output holds its word while the input register still takes one.
// ----------------------------------------------------------------------------
module param_edit_display_controller import pedc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic    advance;
   logic    req_fire;
   cfg_type cfg;
   rsp_type result;

   pedc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   pedc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || advance;
      req_fire     = req_valid && req_ready;
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: rtl/core/pedc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedc_checker
// Port-level checks of the controller's result words, bound to the top level.
// ----------------------------------------------------------------------------
module pedc_checker import pedc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // display fields only on refresh
   a_no_display: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.display_valid |->
         rsp_data.mode_digit == MODE_NORMAL && !rsp_data.value_shown &&
         !rsp_data.hundreds_on && !rsp_data.tens_on &&
         rsp_data.hundreds_digit == 4'd0 && rsp_data.tens_digit == 4'd0 &&
         rsp_data.ones_digit == 4'd0)
      else $error("display fields set outside refresh");

   a_no_write_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.write_kind == WK_NONE |->
         rsp_data.write_target == MODE_NORMAL && rsp_data.write_value == 8'd0)
      else $error("write target or value set without a write");

   a_refused_adjust: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.write_kind == WK_NONE && !rsp_data.display_valid)
      else $error("refused adjust carries a write or display");

endmodule

bind param_edit_display_controller pedc_checker u_pedc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: bench/param_edit_display_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// param_edit_display_checker
// Watches the req, rsp and csr ports of the parameter-edit display controller.
// Keeps its own copy of the edit state and the registers, works out the
// outcome of every accepted command word and checks each response word
// against the oldest outcome still waiting.
// ----------------------------------------------------------------------------
module param_edit_display_checker import pedc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    outstanding,
   output int                    checked
);

   cfg_type     limits;
   logic [1:0]  mode;
   logic [7:0]  value;
   logic        blink_lit;
   logic [31:0] touch_ms;
   logic [31:0] blink_ms_at;
   rsp_type     pending_outcomes[$];

   // wrap-safe elapsed time
   function automatic logic [31:0] elapsed_ms(logic [31:0] now, logic [31:0] then_ms);
      return now - then_ms;
   endfunction

   function automatic logic [7:0] clamp_value(logic [1:0] md, int v);
      int lo;
      int hi;
      case (md)
         MODE_FOLD: begin
            lo = limits.fold_min;
            hi = limits.fold_max;
         end
         MODE_INIT: begin
            lo = limits.init_min;
            hi = limits.init_max;
         end
         default: begin
            lo = limits.speed_min;
            hi = limits.speed_max;
         end
      endcase
      // min is tested first, so crossed bounds give min for values below it
      if (v < lo) v = lo;
      else if (v > hi) v = hi;
      return v[7:0];
   endfunction

   function automatic rsp_type with_digits(rsp_type r, logic [1:0] md, logic [9:0] v,
                                           logic lit);
      int unsigned s;
      r.display_valid = 1'b1;
      r.mode_digit = md;
      if (lit) begin
         s = (v > SHOW_MAX) ? SHOW_MAX : v;
         r.value_shown = 1'b1;
         r.hundreds_on = (s >= 100);
         r.hundreds_digit = 4'(s / 100);
         r.tens_on = (s >= 10);
         r.tens_digit = 4'((s / 10) % 10);
         r.ones_digit = 4'(s % 10);
      end
      return r;
   endfunction

   function automatic rsp_type edit_outcome(req_type w);
      rsp_type    r;
      logic [1:0] cycled_mode;
      r = '0;
      case (w.command)
         CMD_REFRESH: begin
            if (mode != MODE_NORMAL && elapsed_ms(w.now_ms, touch_ms) >= limits.timeout_ms) begin
               r.write_kind = WK_COMMIT;
               r.write_target = mode;
               r.write_value = value;
               mode = MODE_NORMAL;
            end
            if (mode != MODE_NORMAL && elapsed_ms(w.now_ms, blink_ms_at) >= limits.blink_ms) begin
               blink_lit = ~blink_lit;
               blink_ms_at = w.now_ms;
            end
            if (mode == MODE_NORMAL) r = with_digits(r, MODE_NORMAL, w.live_angle, 1'b1);
            else r = with_digits(r, mode, {2'b00, value}, blink_lit);
         end
         CMD_CYCLE: begin
            if (mode != MODE_NORMAL) begin
               r.write_kind = WK_COMMIT;
               r.write_target = mode;
               r.write_value = value;
            end
            cycled_mode = mode + 2'd1;
            if (cycled_mode != MODE_NORMAL) value = w.stored_value;
            mode = cycled_mode;
            blink_lit = 1'b1;
            touch_ms = w.now_ms;
            blink_ms_at = w.now_ms;
         end
         CMD_ADJUST: begin
            if (mode == MODE_NORMAL) begin
               r.status = 1'b1;
            end else begin
               value = clamp_value(mode, int'(value) + int'($signed(w.step)));
               touch_ms = w.now_ms;
               blink_ms_at = w.now_ms;
               blink_lit = 1'b1;
               r.write_kind = WK_LIVE;
               r.write_target = mode;
               r.write_value = value;
            end
         end
         default: begin
            if (w.save && mode != MODE_NORMAL) begin
               r.write_kind = WK_COMMIT;
               r.write_target = mode;
               r.write_value = value;
            end
            mode = MODE_NORMAL;
         end
      endcase
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic compare_word(rsp_type want, rsp_type got);
      check_field("status", want.status, got.status);
      check_field("write_kind", want.write_kind, got.write_kind);
      check_field("write_target", want.write_target, got.write_target);
      check_field("write_value", want.write_value, got.write_value);
      check_field("display_valid", want.display_valid, got.display_valid);
      check_field("mode_digit", want.mode_digit, got.mode_digit);
      check_field("value_shown", want.value_shown, got.value_shown);
      check_field("hundreds_on", want.hundreds_on, got.hundreds_on);
      check_field("hundreds_digit", want.hundreds_digit, got.hundreds_digit);
      check_field("tens_on", want.tens_on, got.tens_on);
      check_field("tens_digit", want.tens_digit, got.tens_digit);
      check_field("ones_digit", want.ones_digit, got.ones_digit);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         limits = '{RST_FOLD_MIN, RST_FOLD_MAX, RST_INIT_MIN, RST_INIT_MAX,
                    RST_SPEED_MIN, RST_SPEED_MAX, RST_TIMEOUT_MS, RST_BLINK_MS};
         mode = MODE_NORMAL;
         value = '0;
         blink_lit = 1'b1;
         touch_ms = '0;
         blink_ms_at = '0;
         pending_outcomes.delete();
         errors = 0;
         checked = 0;
         outstanding = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_FOLD_MIN:   limits.fold_min = csr_wdata[7:0];
               CSR_FOLD_MAX:   limits.fold_max = csr_wdata[7:0];
               CSR_INIT_MIN:   limits.init_min = csr_wdata[7:0];
               CSR_INIT_MAX:   limits.init_max = csr_wdata[7:0];
               CSR_SPEED_MIN:  limits.speed_min = csr_wdata[7:0];
               CSR_SPEED_MAX:  limits.speed_max = csr_wdata[7:0];
               CSR_TIMEOUT_MS: limits.timeout_ms = csr_wdata;
               CSR_BLINK_MS:   limits.blink_ms = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("response word with nothing outstanding");
               errors++;
            end else begin
               compare_word(pending_outcomes.pop_front(), rsp_data);
               checked++;
            end
         end
         if (req_valid && req_ready) pending_outcomes.push_back(edit_outcome(req_data));
         outstanding = pending_outcomes.size();
      end
   end

endmodule

// File: bench/param_edit_display_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// param_edit_display_controller_tb
// Drives command words into the parameter-edit display controller: a directed
// run through mode cycling, clamping, blink, timeout and timestamp wrap, then
// random edit sessions under several register settings, with random idling on
// both channels. Checking is left to the checker instance.
// ----------------------------------------------------------------------------
module param_edit_display_controller_tb;
   import pedc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 275;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int          errors;
   int          outstanding;
   int          checked;
   int          cycles = 0;
   int          sent = 0;
   int          per_cmd[4] = '{0, 0, 0, 0};
   logic        steady = 1'b0;
   logic        hold_rsp = 1'b0;
   cfg_type     cur_cfg = '{RST_FOLD_MIN, RST_FOLD_MAX, RST_INIT_MIN, RST_INIT_MAX,
                            RST_SPEED_MIN, RST_SPEED_MAX, RST_TIMEOUT_MS, RST_BLINK_MS};
   logic [31:0] clock_ms = '0;
   logic [31:0] last_touch = '0;

   param_edit_display_controller uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   param_edit_display_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .outstanding(outstanding), .checked(checked)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("param_edit_display_controller_tb: done, errors");
         $finish;
      end
   end

   // receiver: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 31);
         end
      end
   end

   function automatic req_type make_word(logic [1:0] cmd, logic [31:0] t, int stp, logic sv,
                                         logic [7:0] st, logic [9:0] ang);
      req_type w;
      w.command = cmd;
      w.now_ms = t;
      w.step = 8'(stp);
      w.save = sv;
      w.stored_value = st;
      w.live_angle = ang;
      return w;
   endfunction

   function automatic req_type random_word();
      int      r;
      int      t;
      req_type w;
      r = $urandom_range(99);
      t = $urandom_range(99);
      // time mostly creeps forward; sometimes lands right on the timeout edge or wraps
      if (t < 45) clock_ms = clock_ms + $urandom_range(0, cur_cfg.blink_ms + 16);
      else if (t < 70) clock_ms = clock_ms + $urandom_range(0, cur_cfg.timeout_ms / 2 + 16);
      else if (t < 85) clock_ms = last_touch + cur_cfg.timeout_ms - $urandom_range(0, 1);
      else if (t < 92) clock_ms = clock_ms + $urandom_range(0, 65535);
      else if (t < 96) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else clock_ms = $urandom();
      w = make_word(r < 35 ? CMD_REFRESH : r < 55 ? CMD_CYCLE : r < 85 ? CMD_ADJUST : CMD_EXIT,
                    clock_ms,
                    ($urandom_range(99) < 60) ? int'($urandom_range(0, 20)) - 10
                                              : int'($urandom_range(0, 255)),
                    1'($urandom_range(1)), 8'($urandom_range(255)),
                    10'($urandom_range(1023)));
      return w;
   endfunction

   function automatic cfg_type pick_cfg(int mlo, int mhi, int xlo, int xhi,
                                        int tlo, int thi, int blo, int bhi);
      cfg_type c;
      c.fold_min = 8'($urandom_range(mhi, mlo));
      c.fold_max = 8'($urandom_range(xhi, xlo));
      c.init_min = 8'($urandom_range(mhi, mlo));
      c.init_max = 8'($urandom_range(xhi, xlo));
      c.speed_min = 8'($urandom_range(mhi, mlo));
      c.speed_max = 8'($urandom_range(xhi, xlo));
      c.timeout_ms = 16'($urandom_range(thi, tlo));
      c.blink_ms = 16'($urandom_range(bhi, blo));
      return c;
   endfunction

   task automatic send_word(input req_type w);
      while (!steady && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      per_cmd[w.command]++;
      if (w.command == CMD_CYCLE || w.command == CMD_ADJUST) last_touch = w.now_ms;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      logic [CSR_DATA_W-1:0] vals [CSR_COUNT];
      vals[CSR_FOLD_MIN] = {8'h00, c.fold_min};
      vals[CSR_FOLD_MAX] = {8'h00, c.fold_max};
      vals[CSR_INIT_MIN] = {8'h00, c.init_min};
      vals[CSR_INIT_MAX] = {8'h00, c.init_max};
      vals[CSR_SPEED_MIN] = {8'h00, c.speed_min};
      vals[CSR_SPEED_MAX] = {8'h00, c.speed_max};
      vals[CSR_TIMEOUT_MS] = c.timeout_ms;
      vals[CSR_BLINK_MS] = c.blink_ms;
      for (int i = 0; i < CSR_COUNT; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
      cur_cfg = c;
   endtask

   initial begin
      cfg_type c;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed run at reset settings
      send_word(make_word(CMD_REFRESH, 32'd0, 0, 1'b0, 8'd0, 10'd1023));
      send_word(make_word(CMD_REFRESH, 32'd2, 0, 1'b0, 8'd0, 10'd100));
      send_word(make_word(CMD_ADJUST, 32'd3, -128, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_EXIT, 32'd4, 0, 1'b1, 8'd0, 10'd0));
      send_word(make_word(CMD_CYCLE, 32'd1000, 0, 1'b0, 8'd255, 10'd0));
      send_word(make_word(CMD_ADJUST, 32'd1001, 127, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_ADJUST, 32'd1002, -128, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_REFRESH, 32'd1352, 0, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_REFRESH, 32'd1701, 0, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_REFRESH, 32'd1702, 0, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_CYCLE, 32'd1800, 0, 1'b0, 8'd7, 10'd0));
      send_word(make_word(CMD_ADJUST, 32'd1801, 5, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_CYCLE, 32'd1802, 0, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_ADJUST, 32'd1803, -1, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_ADJUST, 32'd1804, 127, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_EXIT, 32'd1805, 0, 1'b0, 8'd0, 10'd0));
      send_word(make_word(CMD_CYCLE, 32'd2000, 0, 1'b0, 8'd150, 10'd0));
      // one tick short of the timeout, then exactly on it
      send_word(make_word(CMD_REFRESH, 32'd6999, 0, 1'b0, 8'd0, 10'd512));
      send_word(make_word(CMD_REFRESH, 32'd7000, 0, 1'b0, 8'd0, 10'd512));
      send_word(make_word(CMD_CYCLE, 32'hFFFF_FF00, 0, 1'b0, 8'd200, 10'd0));
      send_word(make_word(CMD_REFRESH, 32'h0000_1400, 0, 1'b0, 8'd0, 10'd10));
      // all the way round the modes back to normal
      send_word(make_word(CMD_CYCLE, 32'd5, 0, 1'b0, 8'd30, 10'd0));
      send_word(make_word(CMD_CYCLE, 32'd6, 0, 1'b0, 8'd40, 10'd0));
      send_word(make_word(CMD_CYCLE, 32'd7, 0, 1'b0, 8'd50, 10'd0));
      send_word(make_word(CMD_CYCLE, 32'd8, 0, 1'b0, 8'd60, 10'd0));

      clock_ms = 32'd10000;
      for (int k = 0; k < 250; k++) send_word(random_word());
      drain();

      for (int ph = 1; ph <= 6; ph++) begin
         case (ph)
            1: c = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 16'd0, 16'd0};
            2: c = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 16'hFFFF, 16'hFFFF};
            3, 5: c = pick_cfg(0, 120, 120, 255, 20, 3000, 1, 400);
            4: c = pick_cfg(0, 255, 0, 255, 0, 65535, 0, 65535);
            default: c = pick_cfg(128, 255, 0, 127, 0, 200, 0, 50);
         endcase
         load_config(c);
         steady = (ph == 5);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (ph == 3 && k == 100) hold_rsp = 1'b1;
            if (ph == 4 && k == 140) drain();
            send_word(random_word());
         end
         drain();
      end
      steady = 1'b0;

      $display("covered %0d words (refresh %0d, cycle %0d, adjust %0d, exit %0d)",
               sent, per_cmd[CMD_REFRESH], per_cmd[CMD_CYCLE], per_cmd[CMD_ADJUST],
               per_cmd[CMD_EXIT]);
      $display("seven register settings incl. extremes and crossed bounds, %0d responses checked",
               checked);
      if (errors == 0 && outstanding == 0) begin
         $display("param_edit_display_controller_tb: done, clean");
      end else begin
         $display("param_edit_display_controller_tb: done, errors");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/pedc_pkg.sv
rtl/core/pedc_csr.sv
rtl/core/pedc_digits.sv
rtl/core/pedc_core.sv
rtl/core/param_edit_display_controller.sv
rtl/core/pedc_checker.sv
bench/param_edit_display_checker.sv
bench/param_edit_display_controller_tb.sv
